@@ hw/rtl/rbb_pkg.sv @@
// ----------------------------------------------------------------------------
// rbb_pkg
// shared constants and request codes of the reader byte buffer
// ----------------------------------------------------------------------------
package rbb_pkg;

	localparam int CAPACITY   = 4096;
	localparam int ADDR_W     = $clog2(CAPACITY);
	localparam int POS_W      = $clog2(CAPACITY + 1);
	localparam int SYM_LIMIT  = 128;
	localparam int SYM_W      = 7;
	localparam int HIST_DEPTH = 128;
	localparam int CNT_W      = 13;
	localparam logic [CNT_W-1:0] CNT_MAX   = '1;
	localparam logic [7:0]       END_VALUE = 8'd0;

	localparam logic [2:0] REQ_APPEND  = 3'd0;
	localparam logic [2:0] REQ_GET     = 3'd1;
	localparam logic [2:0] REQ_RETRACT = 3'd2;
	localparam logic [2:0] REQ_MARK    = 3'd3;
	localparam logic [2:0] REQ_RESTORE = 3'd4;
	localparam logic [2:0] REQ_RECOVER = 3'd5;
	localparam logic [2:0] REQ_CLEAR   = 3'd6;
	localparam logic [2:0] REQ_HIST    = 3'd7;

endpackage

@@ hw/rtl/rbb_req_if.sv @@
// ----------------------------------------------------------------------------
// rbb_req_if
// request channel: valid, ready and one request beat
// ----------------------------------------------------------------------------
interface rbb_req_if import rbb_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [2:0]       req_type;
	logic [7:0]       data_byte;
	logic [11:0]      position;
	logic [SYM_W-1:0] symbol_index;

	modport source (output valid, req_type, data_byte, position, symbol_index, input ready);
	modport sink   (input valid, req_type, data_byte, position, symbol_index, output ready);
endinterface

@@ hw/rtl/rbb_res_if.sv @@
// ----------------------------------------------------------------------------
// rbb_res_if
// result channel: valid, ready and one result beat
// ----------------------------------------------------------------------------
interface rbb_res_if import rbb_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             ok;
	logic [7:0]       read_byte;
	logic             full_res;
	logic             empty_res;
	logic [7:0]       checksum;
	logic [CNT_W-1:0] error_count;
	logic [CNT_W-1:0] hist_count;
	logic [POS_W-1:0] write_pos;
	logic [POS_W-1:0] read_pos;
	logic [11:0]      mark_pos;

	modport source (output valid, ok, read_byte, full_res, empty_res, checksum,
		error_count, hist_count, write_pos, read_pos, mark_pos, input ready);
	modport sink   (input valid, ok, read_byte, full_res, empty_res, checksum,
		error_count, hist_count, write_pos, read_pos, mark_pos, output ready);
endinterface

@@ hw/rtl/rbb_ram.sv @@
// ----------------------------------------------------------------------------
// rbb_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module rbb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ hw/rtl/reader_byte_buffer_top.sv @@
// ----------------------------------------------------------------------------
// reader_byte_buffer_top
// byte store with read, write and mark positions, checksum and histogram
//
// one request beat on req gives exactly one result beat on res, in order.
// a request is taken when req.valid meets req.ready: the byte store and the
// histogram ram are read at that edge. the read data comes back in the
// cycle after; when the stage advances the request is resolved, the
// histogram entry is written back and the result is loaded into the
// output register, which raises res.valid. no new request is taken
// while one is held in the stage, so each request is finished before
// the next one is accepted.
// when res is stalled the resolved request holds in its stage and req
// stays low on ready until the output register drains.
// reset clears positions, checksum, error count and the per-entry valid
// bits of the histogram, so every entry reads as zero. clear does the same
// but keeps the mark position. the byte store is not cleared: only entries
// below the write position are ever read.
// ----------------------------------------------------------------------------
module reader_byte_buffer_top import rbb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	rbb_req_if.sink   req,
	rbb_res_if.source res
);

	localparam logic [POS_W-1:0] CAP_POS = POS_W'(CAPACITY);
	localparam logic [8:0]       SYM_LIM9 = 9'(SYM_LIMIT);

	logic [POS_W-1:0] wr_q, rd_q, wr_n, rd_n;
	logic [11:0]      mark_q, mark_n;
	logic [7:0]       sum_q, sum_n;
	logic [CNT_W-1:0] bad_q, bad_n;
	logic             empty_q, empty_n;
	logic [HIST_DEPTH-1:0] hv_q;

	logic             v_s1;
	logic [2:0]       type_s1;
	logic [7:0]       byte_s1;
	logic [11:0]      pos_s1;
	logic [SYM_W-1:0] sym_s1;
	logic             hv_s1;

	logic             accept, adv;
	logic [SYM_W-1:0] hraddr;
	logic [7:0]       store_rdata;
	logic [CNT_W-1:0] hist_rdata, hcnt, hinc;
	logic             store_we, hist_we, clr;
	logic             ok_n;
	logic [7:0]       rbyte_n;
	logic [CNT_W-1:0] hist_n;

	assign req.ready = !v_s1;
	assign accept    = req.valid && !v_s1;
	assign adv       = v_s1 && (!res.valid || res.ready);
	assign hraddr    = (req.req_type == REQ_APPEND) ? req.data_byte[SYM_W-1:0]
		: req.symbol_index;

	rbb_ram #(.WIDTH(8), .DEPTH(CAPACITY)) u_store (
		.clk   (clk),
		.we    (store_we),
		.waddr (wr_q[ADDR_W-1:0]),
		.wdata (byte_s1),
		.re    (accept),
		.raddr (rd_q[ADDR_W-1:0]),
		.rdata (store_rdata)
	);

	rbb_ram #(.WIDTH(CNT_W), .DEPTH(HIST_DEPTH)) u_hist (
		.clk   (clk),
		.we    (hist_we),
		.waddr (byte_s1[SYM_W-1:0]),
		.wdata (hinc),
		.re    (accept),
		.raddr (hraddr),
		.rdata (hist_rdata)
	);

	assign hcnt = hv_s1 ? hist_rdata : '0;
	assign hinc = (hcnt == CNT_MAX) ? hcnt : hcnt + 1'b1;

	always_comb begin
		wr_n     = wr_q;
		rd_n     = rd_q;
		mark_n   = mark_q;
		sum_n    = sum_q;
		bad_n    = bad_q;
		empty_n  = empty_q;
		ok_n     = 1'b0;
		rbyte_n  = 8'd0;
		hist_n   = '0;
		store_we = 1'b0;
		hist_we  = 1'b0;
		clr      = 1'b0;
		unique case (type_s1)
			REQ_APPEND: begin
				if (wr_q < CAP_POS) begin
					store_we = adv;
					wr_n     = wr_q + 1'b1;
					empty_n  = 1'b0;
					sum_n    = sum_q + byte_s1;
					ok_n     = 1'b1;
					if ({1'b0, byte_s1} < SYM_LIM9) begin
						hist_we = adv;
					end else if (bad_q != CNT_MAX) begin
						bad_n = bad_q + 1'b1;
					end
				end
			end
			REQ_GET: begin
				if (rd_q < wr_q) begin
					rbyte_n = store_rdata;
					rd_n    = rd_q + 1'b1;
					ok_n    = 1'b1;
				end else begin
					rbyte_n = END_VALUE;
				end
			end
			REQ_RETRACT: begin
				if (rd_q != '0) begin
					rd_n = rd_q - 1'b1;
					ok_n = 1'b1;
				end
			end
			REQ_MARK: begin
				if ({1'b0, pos_s1} < wr_q) begin
					mark_n = pos_s1;
					ok_n   = 1'b1;
				end
			end
			REQ_RESTORE: begin
				rd_n = {1'b0, mark_q};
				ok_n = 1'b1;
			end
			REQ_RECOVER: begin
				rd_n   = '0;
				mark_n = '0;
				ok_n   = 1'b1;
			end
			REQ_CLEAR: begin
				wr_n    = '0;
				rd_n    = '0;
				sum_n   = '0;
				bad_n   = '0;
				empty_n = 1'b1;
				clr     = adv;
				ok_n    = 1'b1;
			end
			REQ_HIST: begin
				if ({1'b0, sym_s1} < SYM_LIM9) begin
					hist_n = hcnt;
					ok_n   = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			res.valid <= 1'b0;
			wr_q      <= '0;
			rd_q      <= '0;
			mark_q    <= '0;
			sum_q     <= '0;
			bad_q     <= '0;
			empty_q   <= 1'b1;
			hv_q      <= '0;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (adv) begin
				v_s1 <= 1'b0;
			end
			if (adv) begin
				res.valid <= 1'b1;
			end else if (res.ready) begin
				res.valid <= 1'b0;
			end
			if (adv) begin
				wr_q    <= wr_n;
				rd_q    <= rd_n;
				mark_q  <= mark_n;
				sum_q   <= sum_n;
				bad_q   <= bad_n;
				empty_q <= empty_n;
			end
			if (clr) begin
				hv_q <= '0;
			end else if (hist_we) begin
				hv_q[byte_s1[SYM_W-1:0]] <= 1'b1;
			end
		end
	end

	// request stage and result beat payload
	always_ff @(posedge clk) begin
		if (accept) begin
			type_s1 <= req.req_type;
			byte_s1 <= req.data_byte;
			pos_s1  <= req.position;
			sym_s1  <= req.symbol_index;
			hv_s1   <= hv_q[hraddr];
		end
		if (adv) begin
			res.ok          <= ok_n;
			res.read_byte   <= rbyte_n;
			res.full_res    <= (wr_n >= CAP_POS);
			res.empty_res   <= empty_n;
			res.checksum    <= sum_n;
			res.error_count <= bad_n;
			res.hist_count  <= hist_n;
			res.write_pos   <= wr_n;
			res.read_pos    <= rd_n;
			res.mark_pos    <= mark_n;
		end
	end

endmodule
